// File: rtl/core/mgtm_pkg.sv
// Shared constants, types and helpers for the median-gated trimmed mean block
`timescale 1ns / 1ps
package mgtm_pkg;
	localparam int MaxWindowDefault = 32;
	localparam int MinWindow = 5;
	localparam logic [7:0] WindowCountReset = 8'd1;
	localparam logic [15:0] GateReset = 16'd800;

	localparam logic CfgWindowCount = 1'b0;
	localparam logic CfgGateWidth = 1'b1;

	typedef struct packed {
		logic clear_sort;  // raised as the result is loaded; the datapath does not use it
		logic store;       // write arriving word into the window store
		logic insert;      // insertion-sort one word into working array
		logic load_med;    // register median
		logic gate_step;   // accumulate one gated element
		logic trim_init;   // never asserted; the accumulators are cleared under load_med
		logic trim_step;   // trimmed pass step; the trimmed sum itself is accumulated under gate_step
		logic div_start;   // never asserted; the divider starts on the first div_step
		logic div_step;    // divider step: operand load, then one quotient bit
		logic load_out;    // capture result
	} mgtm_cmd_t;

	typedef struct packed {
		logic fallback;    // gated count below N/2
		logic div_done;
	} mgtm_sts_t;
endpackage

// File: rtl/core/mgtm_ctrl.sv
// Controller state machine sequencing collection, sort, gating, trim and division
`timescale 1ns / 1ps
module mgtm_ctrl #(
	parameter int MAX_WINDOW = mgtm_pkg::MaxWindowDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_fire,
	input  logic                       out_free,
	input  logic                       out_fire,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] win_n,
	input  mgtm_pkg::mgtm_sts_t        sts,
	output mgtm_pkg::mgtm_cmd_t        cmd,
	output logic                       in_rdy,
	output logic [$clog2(MAX_WINDOW+1)-1:0] fill_q,
	output logic [$clog2(MAX_WINDOW+1)-1:0] idx_q
);
	localparam int CW = $clog2(MAX_WINDOW + 1);

	typedef enum logic [6:0] {
		ST_COLLECT = 7'b0000001,
		ST_SORT    = 7'b0000010,
		ST_MEDIAN  = 7'b0000100,
		ST_GATE    = 7'b0001000,
		ST_TRIM    = 7'b0010000,
		ST_DIV     = 7'b0100000,
		ST_OUT     = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] last_idx;

	assign last_idx = win_n - CW'(1);
	assign in_rdy = (state_q == ST_COLLECT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_COLLECT: begin
				cmd.store = in_fire;
			end
			ST_SORT: cmd.insert = 1'b1;
			ST_MEDIAN: cmd.load_med = 1'b1;
			ST_GATE: cmd.gate_step = 1'b1;
			ST_TRIM: cmd.trim_step = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_OUT: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
		if (state_q == ST_GATE && idx_q == last_idx)
			cmd.trim_init = 1'b0;
		if (state_q == ST_OUT && out_free)
			cmd.clear_sort = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (in_fire) begin
						if (fill_q + CW'(1) >= win_n) begin
							fill_q  <= '0;
							idx_q   <= '0;
							state_q <= ST_SORT;
						end else begin
							fill_q <= fill_q + CW'(1);
						end
					end
				end
				ST_SORT: begin
					if (idx_q == last_idx) begin
						idx_q   <= '0;
						state_q <= ST_MEDIAN;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_MEDIAN: begin
					idx_q   <= '0;
					state_q <= ST_GATE;
				end
				ST_GATE: begin
					if (idx_q == last_idx) begin
						idx_q   <= '0;
						state_q <= ST_TRIM;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_TRIM: begin
					if (!sts.fallback || idx_q == last_idx) begin
						idx_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_DIV: begin
					if (sts.div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_COLLECT;
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	logic unused_of;
	assign unused_of = out_fire;
endmodule

// File: rtl/core/mgtm_dp.sv
// Datapath: sorted window array, median, gated and trimmed sums, serial divider
`timescale 1ns / 1ps
module mgtm_dp #(
	parameter int MAX_WINDOW = mgtm_pkg::MaxWindowDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mgtm_pkg::mgtm_cmd_t        cmd,
	input  logic signed [15:0]         sample,
	input  logic [15:0]                gate_w,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] win_n,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] fill,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] idx,
	output mgtm_pkg::mgtm_sts_t        sts,
	output logic signed [15:0]         filt_q,
	output logic signed [15:0]         med_out_q,
	output logic                       fb_q,
	output logic [5:0]                 kept_q
);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int IW = $clog2(MAX_WINDOW);
	localparam int AW = 16 + CW;
	localparam int DW = AW + 1;

	// Words kept in arrival order; the closing word takes slot N-1.
	logic signed [15:0] win_q [MAX_WINDOW];
	// Sorted copy, built by insertion of one stored word a cycle.
	logic signed [15:0] srt_q [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] gt;
	logic signed [15:0] ins_val;
	logic [CW-1:0] waddr;
	logic signed [15:0] med_q;
	logic signed [AW-1:0] gacc_q, tacc_q;
	logic [CW-1:0] gcnt_q;
	logic fb;

	assign waddr = (fill + CW'(1) >= win_n) ? win_n - CW'(1) : fill;

	always_ff @(posedge clk) begin
		if (cmd.store) win_q[IW'(waddr)] <= sample;
	end

	assign ins_val = win_q[IW'(idx)];

	always_comb begin
		for (int k = 0; k < MAX_WINDOW; k++)
			gt[k] = (CW'(k) < idx) && (srt_q[k] > ins_val);
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int k = 0; k < MAX_WINDOW; k++) begin
				if (CW'(k) <= idx) begin
					if (k > 0 && gt[(k + MAX_WINDOW - 1) % MAX_WINDOW])
						srt_q[k] <= srt_q[(k + MAX_WINDOW - 1) % MAX_WINDOW];
					else if (CW'(k) == idx || gt[k])
						srt_q[k] <= ins_val;
				end
			end
		end
	end

	// median
	logic [CW-1:0] half;
	logic signed [16:0] msum;
	assign half = win_n >> 1;
	assign msum = 17'(srt_q[IW'(half)]) + 17'(srt_q[IW'(half - CW'(1))]);

	logic signed [AW-1:0] elem;
	logic signed [16:0] diff;
	logic [16:0] adiff;
	assign elem = AW'(srt_q[IW'(idx)]);
	assign diff = 17'(srt_q[IW'(idx)]) - 17'(med_q);
	assign adiff = diff[16] ? 17'(-diff) : 17'(diff);

	logic [CW-1:0] lo;
	assign lo = win_n >> 2;
	assign fb = gcnt_q < half;
	assign sts.fallback = fb;

	// divider state
	logic [AW-1:0] dnum_q, drem_q;
	logic [CW-1:0] dden_q;
	logic [$clog2(AW+1)-1:0] dbit_q;
	logic dneg_q, dbusy_q;
	logic [AW:0] trial;
	logic signed [AW-1:0] acc_sel;
	logic [CW-1:0] cnt_sel;
	assign acc_sel = fb ? tacc_q : gacc_q;
	assign cnt_sel = fb ? win_n - (lo << 1) : gcnt_q;
	assign trial = {drem_q, dnum_q[AW-1]} - {{(AW+1-CW){1'b0}}, dden_q};
	assign sts.div_done = dbusy_q && dbit_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dbit_q  <= '0;
		end else if (cmd.div_step) begin
			if (!dbusy_q) begin
				dbusy_q <= 1'b1;
				dbit_q  <= ($clog2(AW+1))'(AW);
			end else if (dbit_q != '0) begin
				dbit_q <= dbit_q - 1'b1;
			end else begin
				dbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_med) begin
			med_q  <= win_n[0] ? srt_q[IW'(half)] : 16'(msum / 17'sd2);
			gacc_q <= '0;
			tacc_q <= '0;
			gcnt_q <= '0;
		end
		if (cmd.gate_step) begin
			if (adiff <= {1'b0, gate_w}) begin
				gacc_q <= gacc_q + elem;
				gcnt_q <= gcnt_q + CW'(1);
			end
			if (idx >= lo && idx < win_n - lo) tacc_q <= tacc_q + elem;
		end
		if (cmd.div_step) begin
			if (!dbusy_q) begin
				dneg_q <= acc_sel[AW-1];
				dnum_q <= acc_sel[AW-1] ? AW'(-acc_sel) : AW'(acc_sel);
				dden_q <= cnt_sel;
				drem_q <= '0;
			end else if (dbit_q != '0) begin
				if (!trial[AW]) drem_q <= trial[AW-1:0];
				else drem_q <= {drem_q[AW-2:0], dnum_q[AW-1]};
				dnum_q <= {dnum_q[AW-2:0], !trial[AW]};
			end
		end
		if (cmd.load_out) begin
			filt_q    <= dneg_q ? 16'(-dnum_q) : 16'(dnum_q);
			med_out_q <= med_q;
			fb_q      <= fb;
			kept_q    <= 6'(dden_q);
		end
	end

	logic unused_c;
	assign unused_c = cmd.clear_sort ^ cmd.trim_init ^ cmd.trim_step ^ cmd.div_start
		^ (DW != 0);
endmodule

// File: rtl/core/median_gated_trimmed_mean.sv
// Top level of the median-gated trimmed mean filter
// Usage:
//  Input channel sample/in_valid/in_ready takes one signed 16-bit word per
//  handshake, one per cycle while the window fills; words are stored in
//  arrival order. When the window holds N words (window_count clamped to
//  5..32) in_ready drops while the block sorts the window by insertion,
//  takes the median, gates against it, runs the trimmed-mean pass (which
//  walks the window only when the fallback is taken) and the bit-serial
//  division, then loads the output register.
//  The result (filtered_value, median_value, used_fallback, kept_count)
//  sits in an output register under out_valid until out_ready; a stalled
//  receiver holds the block only once a second result is ready.
//  Configuration: cfg_we, cfg_index, cfg_data, written while idle.
//  Reset (arst_n low) empties the window, window_count to 1, gate to 800.
`timescale 1ns / 1ps
module median_gated_trimmed_mean #(
	parameter int MAX_WINDOW = mgtm_pkg::MaxWindowDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] filtered_value,
	output logic signed [15:0] median_value,
	output logic               used_fallback,
	output logic [5:0]         kept_count,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	localparam int CW = $clog2(MAX_WINDOW + 1);

	logic [7:0] wcount_q;
	logic [15:0] gate_q;
	logic [CW-1:0] win_n, fill, idx;
	mgtm_pkg::mgtm_cmd_t cmd;
	mgtm_pkg::mgtm_sts_t sts;
	logic rdy, in_fire, out_fire, out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= mgtm_pkg::WindowCountReset;
			gate_q   <= mgtm_pkg::GateReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mgtm_pkg::CfgWindowCount: wcount_q <= cfg_data[7:0];
				mgtm_pkg::CfgGateWidth:   gate_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (wcount_q < 8'(mgtm_pkg::MinWindow)) win_n = CW'(mgtm_pkg::MinWindow);
		else if (wcount_q > 8'(MAX_WINDOW)) win_n = CW'(MAX_WINDOW);
		else win_n = CW'(wcount_q);
	end

	assign in_ready = rdy;
	assign in_fire  = in_valid && rdy;
	assign out_fire = out_valid && out_ready;
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.load_out) out_valid <= 1'b1;
		else if (out_fire) out_valid <= 1'b0;
	end

	mgtm_ctrl #(.MAX_WINDOW(MAX_WINDOW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.out_fire(out_fire), .win_n(win_n), .sts(sts), .cmd(cmd),
		.in_rdy(rdy), .fill_q(fill), .idx_q(idx)
	);

	mgtm_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sample(sample), .gate_w(gate_q),
		.win_n(win_n), .fill(fill), .idx(idx), .sts(sts),
		.filt_q(filtered_value), .med_out_q(median_value),
		.fb_q(used_fallback), .kept_q(kept_count)
	);

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gate_step |-> !in_ready) else $error("accept during reduction");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready)) else $error("result overwritten");
	a_kept_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> kept_count != 6'd0) else $error("empty mean");
`endif
endmodule

// File: dv/mgtm_checker.sv
// Checker for the median-gated trimmed mean filter: watches both channels and config writes
`timescale 1ns / 1ps
module mgtm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] sample,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] filtered_value,
	input  logic signed [15:0] median_value,
	input  logic               used_fallback,
	input  logic [5:0]         kept_count,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 windows_seen,
	output int                 fallbacks_seen
);
	typedef struct packed {
		logic signed [15:0] filt;
		logic signed [15:0] med;
		logic               fb;
		logic [5:0]         kept;
	} filt_result_t;

	logic [7:0]   win_count;
	logic [15:0]  gate;
	int           fill;
	int           held [32];
	filt_result_t result_q [$];

	assign pending = result_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (window %0d)", what, got, want, windows_seen);
		fail_count++;
	endtask

	function automatic filt_result_t reduce_window(input int n, input int s);
		int b [32];
		int x, j, m, acc, cnt, d, lo;
		filt_result_t r;
		for (int i = 0; i < n - 1; i++) b[i] = held[i];
		b[n-1] = s;
		for (int i = 1; i < n; i++) begin
			x = b[i];
			j = i;
			while (j > 0 && b[j-1] > x) begin
				b[j] = b[j-1];
				j--;
			end
			b[j] = x;
		end
		if (n % 2) m = b[n/2];
		else m = (b[n/2-1] + b[n/2]) / 2;
		acc = 0;
		cnt = 0;
		for (int i = 0; i < n; i++) begin
			d = b[i] - m;
			if (d < 0) d = -d;
			if (d <= int'(gate)) begin
				acc += b[i];
				cnt++;
			end
		end
		r.fb = 1'b0;
		if (cnt < n / 2) begin
			r.fb = 1'b1;
			lo = n / 4;
			acc = 0;
			cnt = 0;
			for (int i = lo; i < n - lo; i++) begin
				acc += b[i];
				cnt++;
			end
		end
		r.filt = 16'(acc / cnt);
		r.med = 16'(m);
		r.kept = 6'(cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int n;
		filt_result_t e;
		if (!arst_n) begin
			win_count <= mgtm_pkg::WindowCountReset;
			gate <= mgtm_pkg::GateReset;
			fill = 0;
			fail_count = 0;
			windows_seen = 0;
			fallbacks_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == mgtm_pkg::CfgWindowCount) win_count <= cfg_data[7:0];
				else gate <= cfg_data;
			end
			if (in_valid && in_ready) begin
				n = win_count < mgtm_pkg::MinWindow ? mgtm_pkg::MinWindow :
					(win_count > 32 ? 32 : win_count);
				if (fill + 1 < n) begin
					held[fill] = sample;
					fill++;
				end else begin
					result_q.push_back(reduce_window(n, sample));
					fill = 0;
				end
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report("unexpected word", filtered_value, 0);
				end else begin
					e = result_q.pop_front();
					windows_seen++;
					if (e.fb) fallbacks_seen++;
					if (filtered_value !== e.filt) report("filtered_value", filtered_value, e.filt);
					if (median_value !== e.med) report("median_value", median_value, e.med);
					if (used_fallback !== e.fb) report("used_fallback", used_fallback, e.fb);
					if (kept_count !== e.kept) report("kept_count", kept_count, e.kept);
				end
			end
		end
	end
endmodule

// File: dv/tb_top.sv
// Testbench top: stimulus, config phases and verdict for the median-gated trimmed mean
`timescale 1ns / 1ps
module tb_top;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] sample;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] filtered_value;
	logic signed [15:0] median_value;
	logic               used_fallback;
	logic [5:0]         kept_count;
	logic               cfg_we;
	logic               cfg_index;
	logic [15:0]        cfg_data;
	int                 fail_count, pending, windows_seen, fallbacks_seen;
	int                 words_sent;
	bit                 calm;
	bit                 hold_off;

	median_gated_trimmed_mean dut (.*);

	mgtm_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("TB_ERROR");
		$finish;
	end

	// sink: random stalls, one long hold-off, a calm stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= !hold_off && (calm || $urandom_range(99) >= 17);
	end

	task automatic send_word(input logic [15:0] v);
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 17) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_word(input logic [15:0] base, input int spread);
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom);
			default: return base + 16'($urandom_range(2 * spread) - spread);
		endcase
	endfunction

	initial begin
		logic [15:0] base;
		int spread, wc, n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = mgtm_pkg::CfgWindowCount;
		cfg_data = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window of 5, gate 800
		send_word(16'h8000); send_word(16'h7fff); send_word(16'h0000);
		send_word(16'hffff); send_word(16'h0001);
		send_word(16'd100); send_word(16'd110); send_word(16'd90);
		send_word(16'd105); send_word(16'd95);
		drain();
		// even window, overflow in the median sum, gate 0 and full gate
		write_reg(mgtm_pkg::CfgWindowCount, 16'd6);
		write_reg(mgtm_pkg::CfgGateWidth, 16'd0);
		repeat (3) send_word(16'h7fff);
		repeat (3) send_word(16'h7ffe);
		drain();
		write_reg(mgtm_pkg::CfgGateWidth, 16'hffff);
		repeat (3) send_word(16'h8000);
		repeat (3) send_word(16'h7fff);
		drain();
		// shrink mid-window
		write_reg(mgtm_pkg::CfgWindowCount, 16'd32);
		repeat (10) send_word(16'($urandom));
		drain();
		write_reg(mgtm_pkg::CfgWindowCount, 16'd7);
		send_word(16'd3);
		drain();

		// random phases; one with a long receiver hold-off
		for (int ph = 0; ph < 24; ph++) begin
			case (ph % 6)
				0: wc = 255;
				1: wc = 1;
				2: wc = 0;
				3: wc = 32;
				default: wc = $urandom_range(255);
			endcase
			write_reg(mgtm_pkg::CfgWindowCount, 16'(wc));
			case ($urandom_range(3))
				0: write_reg(mgtm_pkg::CfgGateWidth, 16'hffff);
				1: write_reg(mgtm_pkg::CfgGateWidth, 16'd0);
				default: write_reg(mgtm_pkg::CfgGateWidth, 16'($urandom_range(3000)));
			endcase
			calm = (ph == 5);
			if (ph == 8) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (3000) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			n = wc < 5 ? 5 : (wc > 32 ? 32 : wc);
			base = 16'($urandom);
			spread = 1 << $urandom_range(12);
			for (int k = 0; k < 72; k++) begin
				if (k % n == 0) begin
					base = 16'($urandom);
					spread = 1 << $urandom_range(12);
				end
				send_word(pick_word(base, spread));
			end
			// finish the open window so none is left half full
			while ((words_sent - 0) >= 0 && chk.fill != 0) send_word(pick_word(base, spread));
			drain();
		end
		calm = 1'b0;
		drain();
		$display("%0d words sent, %0d windows checked, %0d on the trimmed fallback",
			words_sent, windows_seen, fallbacks_seen);
		if (fail_count == 0 && pending == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
